// ----- src/sfr_pkg.sv -----
// Package for the stream find-and-replace block: field widths, configuration
// register indexes and the emission plan passed from the matcher to the emitter.
// Depends on nothing; used by sfr_emit and stream_find_and_replace_core.
package sfr_pkg;

	localparam int BYTE_W     = 8;
	localparam int MAX_LEN    = 8;   // bytes held by the pattern and replacement registers
	localparam int LEN_W      = 4;   // width of a length value, 0 to 8
	localparam int CNT_W      = 5;   // width of a per-transaction byte count, up to 17
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

	// Output of one input transaction: an optional replacement, a run of held
	// bytes, then an optional replacement again.
	typedef struct packed {
		logic             pre;
		logic             post;
		logic             eos;
		logic [LEN_W-1:0] list_len;
		logic [CNT_W-1:0] total;
	} sfr_plan_t;

endpackage

// ----- src/sfr_emit.sv -----
// Output stage of the stream find-and-replace block: holds the plan of one
// input transaction and sends its bytes one per cycle, while out_stall is low, on the output channel.
// Depends on sfr_pkg.
module sfr_emit #(
	parameter int DEPTH = 8,
	parameter int IDX_W = 3
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         load,
	input  sfr_pkg::sfr_plan_t                           plan,
	input  logic [DEPTH-1:0][sfr_pkg::BYTE_W-1:0]        list,
	input  logic [sfr_pkg::LEN_W-1:0]                    rep_len,
	input  logic [sfr_pkg::MAX_LEN-1:0][sfr_pkg::BYTE_W-1:0] rep_bytes,
	output logic                                         busy,
	output logic                                         done,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic [sfr_pkg::BYTE_W-1:0]                   out_byte,
	output logic                                         out_last
);

	localparam int CW = sfr_pkg::CNT_W;

	logic                                  busy_q;
	logic [CW-1:0]                         idx_q;
	sfr_pkg::sfr_plan_t                    plan_q;
	logic [DEPTH-1:0][sfr_pkg::BYTE_W-1:0] list_q;

	logic [sfr_pkg::LEN_W-1:0] pre_len;
	logic [CW-1:0]             rel_idx;
	logic [CW-1:0]             tail_idx;
	logic                      last_byte;

	always_comb begin
		pre_len  = plan_q.pre ? rep_len : '0;
		rel_idx  = idx_q - {1'b0, pre_len};
		tail_idx = rel_idx - {1'b0, plan_q.list_len};
		if (idx_q < {1'b0, pre_len}) begin
			out_byte = rep_bytes[idx_q[2:0]];
		end else if (rel_idx < {1'b0, plan_q.list_len}) begin
			out_byte = list_q[rel_idx[IDX_W-1:0]];
		end else begin
			out_byte = rep_bytes[tail_idx[2:0]];
		end
	end

	assign last_byte = (idx_q == plan_q.total - CW'(1));
	assign out_valid = busy_q;
	assign out_last  = plan_q.eos & last_byte;
	assign busy      = busy_q;
	assign done      = busy_q & ~out_stall & last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && !out_stall) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			plan_q <= plan;
			list_q <= list;
		end
	end

	// A plan is only loaded when it produces at least one byte.
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> plan_q.total != '0)
		else $error("emitter busy with an empty plan");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < plan_q.total)
		else $error("emitter index ran past the plan");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q || done)
		else $error("new plan loaded over an unfinished one");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		done && !load |=> !busy_q)
		else $error("emitter stayed busy after its last byte");

endmodule

// ----- src/stream_find_and_replace_core.sv -----
// Stream find-and-replace: replaces every non-overlapping occurrence of a
// configured pattern in a byte stream with a configured replacement.
// Depends on sfr_pkg and sfr_emit.
//
// Usage: bytes enter on the input channel (in_valid, in_stall, data_byte,
// end_of_stream) and the substituted stream leaves on the output channel
// (out_valid, out_stall, out_byte, out_last). A transaction moves when valid
// is high and stall is low. The pattern, its length, the replacement and its
// length are written through cfg_write, cfg_index and cfg_data while the
// block is idle; writing either pattern register drops any held bytes.
// Each input transaction is matched in the cycle it is taken, and the bytes
// it releases are shown from the next cycle on, one per cycle through a
// single output byte lane. A transaction that releases zero or one byte
// does not stall the input, so such a stream runs at one byte per cycle. A
// transaction that releases n bytes (up to 17 with an empty pattern and end
// of stream) holds in_stall high while all but the last of them drain.
// When the receiver stalls, the current output byte holds and input is
// stalled once the pending bytes cannot be sent. out_last marks the final
// byte of a stream; a stream whose last transaction releases nothing gets no
// out_last. Reset clears the configuration and the window, no clearing pass.
module stream_find_and_replace_core #(
	parameter int PATTERN_MAX     = 8,
	parameter int REPLACEMENT_MAX = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sfr_pkg::BYTE_W-1:0]       data_byte,
	input  logic                             end_of_stream,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sfr_pkg::BYTE_W-1:0]       out_byte,
	output logic                             out_last
);

	localparam int LW        = sfr_pkg::LEN_W;
	localparam int BW        = sfr_pkg::BYTE_W;
	localparam int WIN_DEPTH = (PATTERN_MAX < sfr_pkg::MAX_LEN) ? PATTERN_MAX : sfr_pkg::MAX_LEN;
	localparam int REP_CAP   = (REPLACEMENT_MAX < sfr_pkg::MAX_LEN) ?
		REPLACEMENT_MAX : sfr_pkg::MAX_LEN;
	localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam logic [LW-1:0] WIN_LEN = LW'(WIN_DEPTH);
	localparam logic [LW-1:0] REP_LEN = LW'(REP_CAP);

	logic [sfr_pkg::MAX_LEN-1:0][BW-1:0] pattern_q;
	logic [LW-1:0]                       pattern_len_q;
	logic [sfr_pkg::MAX_LEN-1:0][BW-1:0] rep_q;
	logic [LW-1:0]                       rep_len_q;
	logic [WIN_DEPTH-1:0][BW-1:0]        window_q;
	logic [LW-1:0]                       fill_q;

	logic [LW-1:0]                 p_eff;
	logic [LW-1:0]                 r_eff;
	logic [LW-1:0]                 fill_start;
	logic [LW-1:0]                 fill_inc;
	logic [WIN_DEPTH-1:0][BW-1:0]  win_w;
	logic [WIN_DEPTH-1:0][BW-1:0]  win_shift;
	logic [WIN_DEPTH-1:0][BW-1:0]  list;
	logic [WIN_DEPTH-1:0][BW-1:0]  window_d;
	logic [LW-1:0]                 fill_d;
	logic                          same;
	logic                          full;
	sfr_pkg::sfr_plan_t            plan;
	logic                          in_accept;
	logic                          load;
	logic                          busy;
	logic                          done;

	assign p_eff = (pattern_len_q > WIN_LEN) ? WIN_LEN : pattern_len_q;
	assign r_eff = (rep_len_q > REP_LEN) ? REP_LEN : rep_len_q;

	always_comb begin
		fill_start = (fill_q >= p_eff) ? '0 : fill_q;
		fill_inc   = fill_start + LW'(1);
		win_w      = window_q;
		win_w[fill_start[WIN_IDX_W-1:0]] = data_byte;
		win_shift  = win_w;
		for (int k = 0; k < WIN_DEPTH - 1; k++) begin
			win_shift[k] = win_w[k + 1];
		end
		same = 1'b1;
		for (int k = 0; k < WIN_DEPTH; k++) begin
			if (LW'(k) < p_eff && win_w[k] != pattern_q[k]) begin
				same = 1'b0;
			end
		end
		full = (fill_inc == p_eff);

		plan.eos      = end_of_stream;
		plan.pre      = 1'b0;
		plan.post     = 1'b0;
		plan.list_len = '0;
		list          = win_w;
		window_d      = win_w;
		fill_d        = fill_inc;
		if (p_eff == '0) begin
			// Empty pattern: a replacement before every byte, one more at the end.
			list          = window_q;
			list[0]       = data_byte;
			window_d      = window_q;
			plan.pre      = 1'b1;
			plan.post     = end_of_stream;
			plan.list_len = LW'(1);
			fill_d        = '0;
		end else if (full && same) begin
			plan.pre = 1'b1;
			fill_d   = '0;
		end else if (full) begin
			// Mismatch: release the oldest byte, or the whole window at the end.
			plan.list_len = end_of_stream ? p_eff : LW'(1);
			window_d      = win_shift;
			fill_d        = p_eff - LW'(1);
		end else begin
			plan.list_len = end_of_stream ? fill_inc : '0;
		end
		if (end_of_stream) begin
			fill_d = '0;
		end
		plan.total = ({1'b0, plan.pre ? r_eff : LW'(0)} + {1'b0, plan.list_len})
			+ {1'b0, plan.post ? r_eff : LW'(0)};
	end

	assign in_stall  = busy & ~done;
	assign in_accept = in_valid & ~in_stall;
	assign load      = in_accept & (plan.total != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			pattern_len_q <= '0;
			rep_q         <= '0;
			rep_len_q     <= '0;
			fill_q        <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				sfr_pkg::REG_PATTERN_BYTES: begin
					pattern_q <= cfg_data;
					fill_q    <= '0;
				end
				sfr_pkg::REG_PATTERN_LENGTH: begin
					pattern_len_q <= cfg_data[LW-1:0];
					fill_q        <= '0;
				end
				sfr_pkg::REG_REPLACEMENT_BYTES: begin
					rep_q <= cfg_data;
				end
				sfr_pkg::REG_REPLACEMENT_LENGTH: begin
					rep_len_q <= cfg_data[LW-1:0];
				end
				default: begin
				end
			endcase
		end else if (in_accept) begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			window_q <= window_d;
		end
	end

	sfr_emit #(
		.DEPTH (WIN_DEPTH),
		.IDX_W (WIN_IDX_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.plan      (plan),
		.list      (list),
		.rep_len   (r_eff),
		.rep_bytes (rep_q),
		.busy      (busy),
		.done      (done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	// The window never holds a full pattern between transactions.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 || fill_q < p_eff)
		else $error("match window over-filled");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && end_of_stream && !cfg_write |=> fill_q == '0)
		else $error("window not emptied at end of stream");

	a_pattern_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && (cfg_index == sfr_pkg::REG_PATTERN_BYTES ||
		cfg_index == sfr_pkg::REG_PATTERN_LENGTH) |=> fill_q == '0)
		else $error("pattern write left held bytes");

endmodule

// ----- dv/stream_find_and_replace_core_tb.sv -----
// Self-checking testbench for stream_find_and_replace_core: directed and random byte streams
// under random idling and back-pressure, checked against a behavioral predictor.
// Depends on sfr_pkg and the stream_find_and_replace_core RTL.
module stream_find_and_replace_core_tb;

	localparam int PATTERN_MAX     = 8;
	localparam int REPLACEMENT_MAX = 8;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_ITEMS    = 380;
	localparam int HOLD_CYCLES     = 400;
	localparam int CFG_W           = sfr_pkg::CFG_DATA_W;

	typedef struct packed {
		logic [sfr_pkg::BYTE_W-1:0] data;
		logic                       last;
	} substituted_byte_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_write;
	logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [sfr_pkg::BYTE_W-1:0]     data_byte;
	logic                           end_of_stream;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [sfr_pkg::BYTE_W-1:0]     out_byte;
	logic                           out_last;

	// Predictor state: configuration and the window of undecided bytes.
	logic [63:0]                pattern_word;
	logic [3:0]                 pattern_len;
	logic [63:0]                repl_word;
	logic [3:0]                 repl_len;
	logic [sfr_pkg::BYTE_W-1:0] window [8];
	int                         window_fill;

	substituted_byte_t expected_bytes [$];

	int          mismatch_count = 0;
	int          bytes_checked  = 0;
	int          items_sent     = 0;
	int          config_count   = 0;
	int          burst_left     = 0;
	int          hold_request   = 0;
	int          idle_cycles    = 0;
	bit          narrow_alphabet;
	logic [7:0]  alpha [4];

	stream_find_and_replace_core #(
		.PATTERN_MAX    (PATTERN_MAX),
		.REPLACEMENT_MAX(REPLACEMENT_MAX)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.out_last     (out_last)
	);

	always #1 clk = ~clk;

	function automatic int clamp_len(input logic [3:0] n, input int maxv);
		int m;
		m = n;
		if (m > maxv) m = maxv;
		if (m > 8) m = 8;
		return m;
	endfunction

	function automatic void push_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
		substituted_byte_t e;
		e.data = b;
		e.last = 1'b0;
		expected_bytes.push_back(e);
	endfunction

	function automatic int push_replacement();
		int r;
		int k;
		r = clamp_len(repl_len, REPLACEMENT_MAX);
		for (k = 0; k < r; k++) push_byte(repl_word[8*k +: 8]);
		return r;
	endfunction

	// Works out the bytes released by one input transaction and queues them.
	function automatic void predict_substitution(input logic [sfr_pkg::BYTE_W-1:0] b,
			input logic eos);
		int p;
		int k;
		int count;
		bit same;
		substituted_byte_t tail;
		p = clamp_len(pattern_len, PATTERN_MAX);
		count = 0;
		if (p == 0) begin
			window_fill = 0;
			count += push_replacement();
			push_byte(b);
			count++;
			if (eos) count += push_replacement();
		end else begin
			if (window_fill >= p) window_fill = 0;
			window[window_fill] = b;
			window_fill++;
			if (window_fill == p) begin
				same = 1'b1;
				for (k = 0; k < p; k++)
					if (window[k] != pattern_word[8*k +: 8]) same = 1'b0;
				if (same) begin
					count += push_replacement();
					window_fill = 0;
				end else begin
					push_byte(window[0]);
					count++;
					for (k = 1; k < p; k++) window[k-1] = window[k];
					window_fill--;
				end
			end
			if (eos) begin
				for (k = 0; k < window_fill; k++) push_byte(window[k]);
				count += window_fill;
				window_fill = 0;
			end
		end
		// A stream whose final transaction releases nothing gets no last marker.
		if (eos && count > 0) begin
			tail = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40) $display("MISMATCH at %0t: %s", $time, what);
	endtask

	always @(posedge clk) begin : check_output
		substituted_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %h last %b", out_byte, out_last));
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				if (out_byte !== want.data)
					report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.data));
				if (out_last !== want.last)
					report_mismatch($sformatf("out_last %b, expected %b (byte %h)",
						out_last, want.last, want.data));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles, %0d bytes still expected",
				WATCHDOG_LIMIT, expected_bytes.size());
			$display("stream_find_and_replace_core_tb failed");
			$finish;
		end
	end

	// Receiver: switches between stall patterns, and honors a long hold-off request.
	initial begin : receiver
		stall_mode_t mode;
		int mode_left;
		int hold_left;
		int tick;
		mode = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 100);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					STALL_NONE:     out_stall <= 1'b0;
					STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
					STALL_PERIODIC: out_stall <= ((tick % 5) < 2);
					default:        out_stall <= 1'b0;
				endcase
			end
		end
	end

	task automatic set_config(input logic [63:0] pat, input logic [3:0] pat_n,
			input logic [63:0] rep, input logic [3:0] rep_n);
		cfg_write <= 1'b1;
		cfg_index <= sfr_pkg::REG_PATTERN_BYTES;
		cfg_data  <= pat;
		@(posedge clk);
		cfg_index <= sfr_pkg::REG_PATTERN_LENGTH;
		cfg_data  <= CFG_W'(pat_n);
		@(posedge clk);
		cfg_index <= sfr_pkg::REG_REPLACEMENT_BYTES;
		cfg_data  <= rep;
		@(posedge clk);
		cfg_index <= sfr_pkg::REG_REPLACEMENT_LENGTH;
		cfg_data  <= CFG_W'(rep_n);
		@(posedge clk);
		cfg_write <= 1'b0;
		pattern_word = pat;
		pattern_len  = pat_n;
		repl_word    = rep;
		repl_len     = rep_n;
		window_fill  = 0;
		config_count++;
		@(posedge clk);
	endtask

	// Offers one byte; the sender runs in bursts separated by random gaps.
	task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid      <= 1'b1;
		data_byte     <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_substitution(b, eos);
		items_sent++;
	endtask

	// Stops offering, waits for every expected byte, then lets the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		if (narrow_alphabet) return alpha[$urandom_range(0, 3)];
		return 8'($urandom);
	endfunction

	task automatic test_reset_passthrough();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_match_and_flush();
		set_config(64'h6261, 4'd2, 64'h5A5958, 4'd3);
		send_byte(8'h78, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h63, 1'b1);
		wait_idle();
	endtask

	// A match on the final byte with an empty replacement leaves nothing to mark last.
	task automatic test_silent_end();
		set_config(64'h6261, 4'd2, 64'h5A5958, 4'd0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);
		send_byte(8'h71, 1'b1);
		wait_idle();
	endtask

	task automatic test_empty_pattern();
		set_config(64'h0, 4'd0, 64'h0123456789ABCDEF, 4'd8);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);
		wait_idle();
	endtask

	task automatic test_oversized_lengths();
		int k;
		set_config({64{1'b1}}, 4'hF, 64'hF0E1D2C3B4A59687, 4'hF);
		for (k = 0; k < 7; k++) send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		wait_idle();
	endtask

	// Rewriting the pattern between bytes of one stream must drop the held bytes.
	task automatic test_pattern_rewrite();
		set_config(64'h64636261, 4'd4, 64'h2B2A, 4'd2);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		wait_idle();
		set_config(64'h64636261, 4'd4, 64'h2B2A, 4'd2);
		send_byte(8'h63, 1'b0);
		send_byte(8'h64, 1'b1);
		wait_idle();
	endtask

	task automatic pick_random_config(input int phase);
		logic [63:0] pat;
		logic [63:0] rep;
		logic [3:0]  pat_n;
		logic [3:0]  rep_n;
		int k;
		narrow_alphabet = ($urandom_range(0, 3) != 0);
		alpha[0] = 8'h00;
		alpha[1] = 8'hFF;
		alpha[2] = 8'($urandom);
		alpha[3] = 8'($urandom);
		for (k = 0; k < 8; k++) pat[8*k +: 8] = pick_byte();
		rep = {$urandom, $urandom};
		case (phase)
			0: begin pat_n = 4'd8;  rep_n = 4'd8;  end
			1: begin pat_n = 4'd15; rep_n = 4'd0;  end
			2: begin pat_n = 4'd0;  rep_n = 4'd15; end
			3: begin pat_n = 4'd1;  rep_n = 4'd1;  end
			default: begin
				case ($urandom_range(0, 5))
					0:       pat_n = 4'd0;
					1:       pat_n = 4'd1;
					2:       pat_n = 4'd8;
					3:       pat_n = 4'($urandom_range(9, 15));
					default: pat_n = 4'($urandom_range(2, 6));
				endcase
				rep_n = 4'($urandom_range(0, 15));
			end
		endcase
		set_config(pat, pat_n, rep, rep_n);
	endtask

	// Mostly pattern occurrences and near misses, some plain bytes; a few streams
	// run on without an end marker into the next one.
	task automatic send_random_stream();
		logic [7:0] seq [$];
		int len;
		int p;
		int k;
		int n;
		int choice;
		bit broken;
		p = clamp_len(pattern_len, PATTERN_MAX);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12);
		broken = ($urandom_range(0, 7) == 0);
		while (seq.size() < len) begin
			choice = $urandom_range(0, 9);
			if (p > 0 && choice < 4) begin
				for (k = 0; k < p; k++) seq.push_back(pattern_word[8*k +: 8]);
			end else if (p > 1 && choice < 6) begin
				n = $urandom_range(1, p - 1);
				for (k = 0; k < n; k++) seq.push_back(pattern_word[8*k +: 8]);
			end else begin
				seq.push_back(pick_byte());
			end
		end
		for (k = 0; k < seq.size(); k++) send_byte(seq[k], !broken && k == seq.size() - 1);
	endtask

	task automatic test_random_streams();
		int phase;
		int target;
		int phase_end;
		phase = 0;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			pick_random_config(phase);
			phase_end = items_sent + $urandom_range(20, 50);
			while (items_sent < phase_end) send_random_stream();
			wait_idle();
			phase++;
		end
	endtask

	// The receiver holds off while an expanding replacement fills the block.
	task automatic test_backpressure();
		int k;
		set_config(64'h4241, 4'd2, 64'h3837363534333231, 4'd8);
		narrow_alphabet = 1'b1;
		alpha[0] = 8'h41;
		alpha[1] = 8'h42;
		alpha[2] = 8'h00;
		alpha[3] = 8'hFF;
		hold_request = HOLD_CYCLES;
		for (k = 0; k < 60; k++) send_byte((k % 7 == 6) ? pick_byte() : ((k % 2) ? 8'h42 : 8'h41),
			k == 59);
		wait_idle();
		for (k = 0; k < 20; k++) send_byte(pick_byte(), k == 19);
		wait_idle();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = sfr_pkg::REG_PATTERN_BYTES;
		cfg_data      = '0;
		in_valid      = 1'b0;
		data_byte     = '0;
		end_of_stream = 1'b0;
		pattern_word  = '0;
		pattern_len   = '0;
		repl_word     = '0;
		repl_len      = '0;
		window_fill   = 0;
		narrow_alphabet = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_passthrough();
		test_match_and_flush();
		test_silent_end();
		test_empty_pattern();
		test_oversized_lengths();
		test_pattern_rewrite();
		test_random_streams();
		test_backpressure();
		wait_idle();

		$display("Sent %0d input bytes under %0d configurations; checked %0d output bytes.",
			items_sent, config_count, bytes_checked);
		$display("Included empty and oversized lengths, a mid-stream pattern rewrite %s",
			"and a long hold-off.");
		if (mismatch_count == 0) begin
			$display("stream_find_and_replace_core_tb passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("stream_find_and_replace_core_tb failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/sfr_pkg.sv
src/sfr_emit.sv
src/stream_find_and_replace_core.sv
dv/stream_find_and_replace_core_tb.sv
